@@ rtl/jmad_pkg.sv @@
`timescale 1ns / 1ps

package jmad_pkg;

    localparam int DEF_WINDOW_LENGTH = 6;
    localparam int DEF_SAMPLE_BITS   = 13;
    localparam int DEAD_ZONE_BITS    = 13;
    localparam int ANGLE_BITS        = 32;
    localparam int CENTER_RAW        = 2048;

    localparam logic [DEAD_ZONE_BITS-1:0] DEAD_ZONE_RESET = DEAD_ZONE_BITS'(80);

    typedef struct packed {
        logic sum_en;
        logic prod_en;
        logic delta_en;
        logic acc_en;
    } t_stage_en;

endpackage

@@ rtl/jmad_if.sv @@
`timescale 1ns / 1ps

interface jmad_in_if #(
    parameter int SAMPLE_BITS = 13
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic                   button_level;

    modport source (output valid, output sample_x, output sample_y,
                    output button_level, input ready);
    modport sink (input valid, input sample_x, input sample_y,
                  input button_level, output ready);
endinterface

interface jmad_out_if #(
    parameter int SAMPLE_BITS = 13,
    parameter int ANGLE_BITS  = 32
);
    logic                          valid;
    logic                          ready;
    logic        [SAMPLE_BITS-1:0] average_x;
    logic        [SAMPLE_BITS-1:0] average_y;
    logic signed [SAMPLE_BITS:0]   delta_x;
    logic signed [SAMPLE_BITS:0]   delta_y;
    logic signed [ANGLE_BITS-1:0]  pitch_angle;
    logic signed [ANGLE_BITS-1:0]  yaw_angle;
    logic                          moved;
    logic                          button_changed;

    modport source (output valid, output average_x, output average_y,
                    output delta_x, output delta_y, output pitch_angle,
                    output yaw_angle, output moved, output button_changed,
                    input ready);
    modport sink (input valid, input average_x, input average_y,
                  input delta_x, input delta_y, input pitch_angle,
                  input yaw_angle, input moved, input button_changed,
                  output ready);
endinterface

@@ rtl/jmad_cell.sv @@
`timescale 1ns / 1ps

module jmad_cell #(
    parameter int                 WIDTH       = 13,
    parameter logic [WIDTH-1:0]   RESET_VALUE = '0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [WIDTH-1:0] i_value,
    output logic [WIDTH-1:0] o_value
);

    logic [WIDTH-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= RESET_VALUE;
        end else if (i_shift) begin
            r_value <= i_value;
        end
    end

    assign o_value = r_value;

endmodule

@@ rtl/jmad_axis.sv @@
`timescale 1ns / 1ps

module jmad_axis #(
    parameter int WINDOW_LENGTH = 6,
    parameter int SAMPLE_BITS   = 13
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  jmad_pkg::t_stage_en                    i_ctl,
    input  logic [SAMPLE_BITS-1:0]                 i_sample,
    input  logic [jmad_pkg::DEAD_ZONE_BITS-1:0]    i_dead_zone,
    output logic [SAMPLE_BITS-1:0]                 o_average,
    output logic signed [SAMPLE_BITS:0]            o_delta,
    output logic signed [jmad_pkg::ANGLE_BITS-1:0] o_angle
);

    import jmad_pkg::*;

    localparam int WIN_LOG2   = $clog2(WINDOW_LENGTH);
    localparam int SUM_BITS   = SAMPLE_BITS + WIN_LOG2;
    localparam int SHIFT      = SUM_BITS + WIN_LOG2;
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam int CMP_BITS   = (SAMPLE_BITS > DEAD_ZONE_BITS) ? SAMPLE_BITS : DEAD_ZONE_BITS;
    localparam int CENTER_INT = (SAMPLE_BITS > 11) ? CENTER_RAW : 0;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RECIP_BITS-1:0]  RECIP     = RECIP_BITS'(RECIP_FULL);
    localparam logic [SAMPLE_BITS-1:0] CENTER    = SAMPLE_BITS'(CENTER_INT);
    localparam logic [SUM_BITS-1:0]    SUM_RESET = SUM_BITS'(WINDOW_LENGTH * CENTER_INT);
    localparam logic signed [ANGLE_BITS-1:0] ANGLE_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam logic signed [ANGLE_BITS-1:0] ANGLE_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] w_tap [WINDOW_LENGTH];

    genvar k;
    generate
        for (k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                jmad_cell #(.WIDTH(SAMPLE_BITS), .RESET_VALUE(CENTER)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_ctl.sum_en),
                    .i_value (i_sample),
                    .o_value (w_tap[k])
                );
            end else begin : g_body
                jmad_cell #(.WIDTH(SAMPLE_BITS), .RESET_VALUE(CENTER)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_ctl.sum_en),
                    .i_value (w_tap[k-1]),
                    .o_value (w_tap[k])
                );
            end
        end
    endgenerate

    logic [SUM_BITS-1:0]           r_sum;
    logic [SUM_BITS-1:0]           n_sum;
    logic [PROD_BITS-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0]        r_avg;
    logic [SAMPLE_BITS-1:0]        w_avg;
    logic signed [SAMPLE_BITS:0]   w_change;
    logic [SAMPLE_BITS-1:0]        w_mag;
    logic signed [SAMPLE_BITS:0]   n_delta;
    logic signed [SAMPLE_BITS:0]   r_delta;
    logic signed [ANGLE_BITS:0]    w_total;
    logic signed [ANGLE_BITS-1:0]  n_acc;
    logic signed [ANGLE_BITS-1:0]  r_acc;
    logic [SAMPLE_BITS-1:0]        r_out_avg;
    logic signed [SAMPLE_BITS:0]   r_out_delta;

    // The running sum drops the sample leaving the last cell as the new one enters.
    assign n_sum = r_sum + SUM_BITS'(i_sample) - SUM_BITS'(w_tap[WINDOW_LENGTH-1]);

    assign w_avg    = r_prod[SHIFT +: SAMPLE_BITS];
    assign w_change = $signed({1'b0, w_avg}) - $signed({1'b0, r_avg});
    assign w_mag    = w_change[SAMPLE_BITS] ? SAMPLE_BITS'(-w_change)
                                            : w_change[SAMPLE_BITS-1:0];

    always_comb begin
        if (CMP_BITS'(w_mag) < CMP_BITS'(i_dead_zone)) begin
            n_delta = '0;
        end else begin
            n_delta = w_change;
        end
    end

    assign w_total = {r_acc[ANGLE_BITS-1], r_acc}
                   + (ANGLE_BITS+1)'(r_delta);

    always_comb begin
        if (w_total[ANGLE_BITS] != w_total[ANGLE_BITS-1]) begin
            n_acc = w_total[ANGLE_BITS] ? ANGLE_MIN : ANGLE_MAX;
        end else begin
            n_acc = w_total[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_RESET;
            r_avg <= CENTER;
            r_acc <= '0;
        end else begin
            if (i_ctl.sum_en) begin
                r_sum <= n_sum;
            end
            if (i_ctl.delta_en) begin
                r_avg <= w_avg;
            end
            if (i_ctl.acc_en) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= PROD_BITS'(r_sum) * PROD_BITS'(RECIP);
        end
        if (i_ctl.delta_en) begin
            r_delta <= n_delta;
        end
        if (i_ctl.acc_en) begin
            r_out_avg   <= r_avg;
            r_out_delta <= r_delta;
        end
    end

    assign o_average = r_out_avg;
    assign o_delta   = r_out_delta;
    assign o_angle   = r_acc;

endmodule

@@ rtl/joystick_moving_average_deadzone.sv @@
`timescale 1ns / 1ps

// Joystick filter: each accepted word carries one X and one Y sample and the
// button level, and gives exactly one result word with the six-sample moving
// averages, their changes after the dead zone, the saturating pitch and yaw
// angles in milliradians, a motion flag and a button-change flag. The block
// takes one word every clock cycle unless the output stalls, and its result passes
// through a four-stage pipeline of running sum over the chain of
// sample cells, reciprocal multiply, dead-zone compare and accumulate; each
// stage holds its word while the next one is full and cannot move on. The dead
// zone register resets to 80 and should be written only while no word is in flight.
module joystick_moving_average_deadzone #(
    parameter int WINDOW_LENGTH = jmad_pkg::DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = jmad_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jmad_pkg::DEAD_ZONE_BITS-1:0] i_cfg_wdata,
    jmad_in_if.sink                             i_in,
    jmad_out_if.source                          o_out
);

    import jmad_pkg::*;

    logic [DEAD_ZONE_BITS-1:0] r_dead_zone;
    logic                      r_prev_btn;
    logic                      r_v_sum;
    logic                      r_v_prod;
    logic                      r_v_delta;
    logic                      r_v_out;
    logic                      n_v_sum;
    logic                      n_v_prod;
    logic                      n_v_delta;
    logic                      n_v_out;
    logic                      r_chg_sum;
    logic                      r_chg_prod;
    logic                      r_chg_delta;
    logic                      r_chg_out;
    logic                      w_rdy_sum;
    logic                      w_rdy_prod;
    logic                      w_rdy_delta;
    logic                      w_rdy_out;
    t_stage_en                 w_ctl;

    assign w_rdy_out   = !r_v_out || o_out.ready;
    assign w_rdy_delta = !r_v_delta || w_rdy_out;
    assign w_rdy_prod  = !r_v_prod || w_rdy_delta;
    assign w_rdy_sum   = !r_v_sum || w_rdy_prod;

    always_comb begin
        w_ctl.sum_en   = i_in.valid && w_rdy_sum;
        w_ctl.prod_en  = r_v_sum && w_rdy_prod;
        w_ctl.delta_en = r_v_prod && w_rdy_delta;
        w_ctl.acc_en   = r_v_delta && w_rdy_out;
    end

    always_comb begin
        n_v_sum   = w_ctl.sum_en || (r_v_sum && !w_ctl.prod_en);
        n_v_prod  = w_ctl.prod_en || (r_v_prod && !w_ctl.delta_en);
        n_v_delta = w_ctl.delta_en || (r_v_delta && !w_ctl.acc_en);
        n_v_out   = w_ctl.acc_en || (r_v_out && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_ZONE_RESET;
            r_prev_btn  <= 1'b0;
            r_v_sum     <= 1'b0;
            r_v_prod    <= 1'b0;
            r_v_delta   <= 1'b0;
            r_v_out     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dead_zone <= i_cfg_wdata;
            end
            if (w_ctl.sum_en) begin
                r_prev_btn <= i_in.button_level;
            end
            r_v_sum   <= n_v_sum;
            r_v_prod  <= n_v_prod;
            r_v_delta <= n_v_delta;
            r_v_out   <= n_v_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.sum_en) begin
            r_chg_sum <= i_in.button_level != r_prev_btn;
        end
        if (w_ctl.prod_en) begin
            r_chg_prod <= r_chg_sum;
        end
        if (w_ctl.delta_en) begin
            r_chg_delta <= r_chg_prod;
        end
        if (w_ctl.acc_en) begin
            r_chg_out <= r_chg_delta;
        end
    end

    jmad_axis #(.WINDOW_LENGTH(WINDOW_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sample    (i_in.sample_x),
        .i_dead_zone (r_dead_zone),
        .o_average   (o_out.average_x),
        .o_delta     (o_out.delta_x),
        .o_angle     (o_out.yaw_angle)
    );

    jmad_axis #(.WINDOW_LENGTH(WINDOW_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sample    (i_in.sample_y),
        .i_dead_zone (r_dead_zone),
        .o_average   (o_out.average_y),
        .o_delta     (o_out.delta_y),
        .o_angle     (o_out.pitch_angle)
    );

    assign i_in.ready           = w_rdy_sum;
    assign o_out.valid          = r_v_out;
    assign o_out.moved          = (o_out.delta_x != '0) || (o_out.delta_y != '0);
    assign o_out.button_changed = r_chg_out;

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rdy_sum |-> (r_v_sum && r_v_prod && r_v_delta && r_v_out))
        else $error("Input stalled while a pipeline stage was empty.");

    a_acc_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.acc_en |=> r_v_out)
        else $error("Accumulated word did not reach the output register.");

    a_delta_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_delta && !w_rdy_out) |=> r_v_delta)
        else $error("Delta stage word lost while the output was blocked.");

    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.sum_en && !w_ctl.prod_en) |=> r_v_sum)
        else $error("Accepted word was not held in the sum stage.");

endmodule
